### hdl/vlbp_pkg.sv
// shared constants and types for the variable length bit packer
`timescale 1ns / 1ps

package vlbp_pkg;

    localparam int BLOCK_BYTES   = 256;
    localparam int MAX_CODE_BITS = 32;
    localparam int BYTE_BITS     = 8;
    localparam int CODE_W        = 32;
    localparam int LEN_W         = 6;
    localparam int LEN_CAP       = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
    localparam int PEND_W        = BYTE_BITS - 1;
    localparam int ACC_W         = CODE_W + PEND_W;
    localparam int SLOT_W        = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // one accepted item as handed from the packer to the byte emitter
    typedef struct packed {
        logic [CODE_W-1:0] bytes;
        logic [2:0]        count;
        logic              flush;
        logic [2:0]        flush_bits;
    } vlbp_work_t;

endpackage

### hdl/vlbp_pack.sv
// packer stage: appends code bits to the pending bits and registers the finished bytes or the flushed partial byte
`timescale 1ns / 1ps

module vlbp_pack
    import vlbp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_len,
    output vlbp_work_t        work,
    output logic              work_valid,
    input  logic              work_done
);

    logic [PEND_W-1:0] pbits_reg, pbits_next;
    logic [2:0]        pcnt_reg, pcnt_next;
    logic              work_valid_reg, work_valid_next;
    vlbp_work_t        work_reg, work_next;

    logic [LEN_W-1:0]  len_sat;
    logic [CODE_W-1:0] mask;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  rest;
    logic [LEN_W-1:0]  total;
    logic [2:0]        nbytes;
    logic              accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = !work_valid_reg || work_done;

    always_comb begin
        len_sat = (code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_len;
        mask    = (len_sat >= LEN_W'(CODE_W)) ? '1 : ((CODE_W'(1) << len_sat) - CODE_W'(1));
        acc     = ({{PEND_W{1'b0}}, code_bits & mask} << pcnt_reg)
                | {{CODE_W{1'b0}}, pbits_reg};
        total   = LEN_W'(pcnt_reg) + len_sat;
        nbytes  = total[LEN_W-1:3];
        rest    = acc >> {nbytes, 3'b000};
    end

    always_comb begin
        pbits_next      = pbits_reg;
        pcnt_next       = pcnt_reg;
        work_next       = work_reg;
        work_valid_next = work_valid_reg;
        if (work_done) begin
            work_valid_next = 1'b0;
        end
        if (accept) begin
            work_valid_next = 1'b1;
            if (func == FUNC_FLUSH) begin
                work_next.bytes      = {{(CODE_W-PEND_W){1'b0}}, pbits_reg};
                work_next.count      = (pcnt_reg != 3'd0) ? 3'd1 : 3'd0;
                work_next.flush      = 1'b1;
                work_next.flush_bits = pcnt_reg;
                pbits_next           = '0;
                pcnt_next            = '0;
            end else begin
                // a zero length append leaves total and rest equal to the pending state
                work_next.bytes      = acc[CODE_W-1:0];
                work_next.count      = nbytes;
                work_next.flush      = 1'b0;
                work_next.flush_bits = '0;
                pbits_next           = rest[PEND_W-1:0];
                pcnt_next            = total[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pbits_reg      <= '0;
            pcnt_reg       <= '0;
            work_valid_reg <= 1'b0;
        end else begin
            pbits_reg      <= pbits_next;
            pcnt_reg       <= pcnt_next;
            work_valid_reg <= work_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    assign work       = work_reg;
    assign work_valid = work_valid_reg;

endmodule

### hdl/vlbp_emit.sv
// byte emitter: walks the bytes of one item into the output register, tracks the block slot
`timescale 1ns / 1ps

module vlbp_emit
    import vlbp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  vlbp_work_t work,
    input  logic       work_valid,
    output logic       work_done,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [7:0] byte_slot,
    output logic [3:0] valid_bits,
    output logic       block_full,
    output logic       last
);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [1:0]        idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [7:0]        byte_reg;
    logic [7:0]        bslot_reg;
    logic [3:0]        vbits_reg;
    logic              full_reg;
    logic              last_reg;

    logic              out_free;
    logic              is_last;
    logic              emit;
    logic              full;
    logic [SLOT_W+7:0] slot_ext;
    logic [7:0]        cur_byte;

    always_comb begin
        out_free  = !valid_reg || out_ready;
        is_last   = (idx_reg == 2'(work.count - 3'd1));
        emit      = work_valid && (work.count != 3'd0) && out_free;
        work_done = work_valid && ((work.count == 3'd0) || (out_free && is_last));
        full      = work.flush || (slot_reg == SLOT_W'(BLOCK_BYTES - 1));
        slot_ext  = {8'd0, slot_reg};
        cur_byte  = work.bytes[{idx_reg, 3'b000} +: 8];
    end

    always_comb begin
        slot_next  = slot_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (emit) begin
            valid_next = 1'b1;
            slot_next  = full ? '0 : slot_reg + SLOT_W'(1);
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end else if (work_valid && (work.count == 3'd0) && work.flush) begin
            // flush with nothing pending still starts a new block
            slot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            slot_reg  <= slot_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg  <= cur_byte;
            bslot_reg <= slot_ext[7:0];
            vbits_reg <= work.flush ? {1'b0, work.flush_bits} : 4'(BYTE_BITS);
            full_reg  <= full;
            last_reg  <= is_last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign byte_slot  = bslot_reg;
    assign valid_bits = vbits_reg;
    assign block_full = full_reg;
    assign last       = last_reg;

endmodule

### hdl/variable_length_bit_packer_unit.sv
// Variable length bit packer: appends codes of 0 to 32 bits LSB first and streams out
// finished bytes with their slot in a 256-byte block; a flush word emits the partial byte.
// Each input word is registered on acceptance; its completed bytes (up to four) then leave
// through the output register at one byte per cycle unless the output stalls, and the next
// word is taken in the cycle the last byte of the current one moves to the output register.
// The first byte of a word passes through the work register and then the output register.
// Codes longer than the cap are cut to it; a zero length append gives no byte.
`timescale 1ns / 1ps

module variable_length_bit_packer_unit
    import vlbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // code_bits[31:0], code_len[37:32], zero [39:38]
    input  logic        s_tuser,   // func: 0 append, 1 flush
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte[7:0], byte_slot[15:8], valid_bits[19:16], zero
    output logic        m_tuser,   // block_full
    output logic        m_tlast    // last byte caused by the input word
);

    vlbp_work_t work;
    logic       work_valid;
    logic       work_done;
    logic [7:0] out_byte;
    logic [7:0] byte_slot;
    logic [3:0] valid_bits;

    vlbp_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tuser),
        .code_bits  (s_tdata[31:0]),
        .code_len   (s_tdata[37:32]),
        .work       (work),
        .work_valid (work_valid),
        .work_done  (work_done)
    );

    vlbp_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .work       (work),
        .work_valid (work_valid),
        .work_done  (work_done),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .byte_slot  (byte_slot),
        .valid_bits (valid_bits),
        .block_full (m_tuser),
        .last       (m_tlast)
    );

    assign m_tdata = {4'd0, valid_bits, byte_slot, out_byte};

endmodule

### hdl/vlbp_checker.sv
// port checker for the variable length bit packer, bound to the top level
`timescale 1ns / 1ps

module vlbp_checker
    import vlbp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // no word comes out in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output word changed");

    a_vbits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:16] != 4'd0) && (m_tdata[19:16] <= 4'(BYTE_BITS)))
        else $error("valid_bits out of range");

    // a partial byte only comes from a flush, which ends the block and the word
    a_partial_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[19:16] != 4'(BYTE_BITS)) |-> m_tuser && m_tlast)
        else $error("partial byte without block end");

    // a full byte that closes a block sits in the last slot
    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && (m_tdata[19:16] == 4'(BYTE_BITS))
            |-> m_tdata[15:8] == 8'(BLOCK_BYTES - 1))
        else $error("block end on a byte outside the last slot");

endmodule

bind variable_length_bit_packer_unit vlbp_checker u_vlbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
